// ===== rtl/core/stb_pkg.sv =====
`default_nettype none

package stb_pkg;

  // Default table depth handed to the top level.
  localparam int STB_DEPTH_DEF = 8;

  // Fixed field widths of the item and result beats.
  localparam int SLOT_W    = 3;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 3;
  localparam int ENTRIES_W = 4;

  // Request kinds carried in req_type.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Configuration register map (word index taken from paddr[2]).
  localparam int  PADDR_W          = 3;
  localparam logic REG_IDX_ENTRIES = 1'b0;

  // Value of entries_in_use after reset.
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 4'd8;

  // One queued command between the front and the back.
  typedef struct packed {
    logic                     is_lookup;
    logic [SLOT_W-1:0]        slot;
    logic signed [KEY_W-1:0]  value;
  } stb_cmd_t;

endpackage : stb_pkg

`default_nettype wire

// ===== rtl/core/stb_front.sv =====
`default_nettype none

module stb_front import stb_pkg::*; #(
  parameter int TABLE_DEPTH = STB_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_req_type,
  input  wire logic [SLOT_W-1:0]       in_slot,
  input  wire logic signed [KEY_W-1:0] in_item_value,
  output logic                         q_valid,
  output stb_cmd_t                     q_cmd,
  input  wire logic                    q_pop
);

  localparam int QDEPTH = 2;

  stb_cmd_t    q_r [QDEPTH];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        accept;
  logic        slot_ok;
  logic        push;

  // A beat is taken whenever the queue has room.
  assign in_stall = (count_r == 2'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  // Writes to slots past the table end are dropped here and never queued.
  assign slot_ok = (32'(in_slot) < 32'(TABLE_DEPTH));
  assign push    = accept && ((in_req_type == REQ_LOOKUP) || slot_ok);

  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = q_r[rptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wptr_nxt  = push  ? !wptr_r : wptr_r;
    rptr_nxt  = q_pop ? !rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r].is_lookup <= (in_req_type == REQ_LOOKUP);
      q_r[wptr_r].slot      <= in_slot;
      q_r[wptr_r].value     <= in_item_value;
    end
  end

endmodule : stb_front

`default_nettype wire

// ===== rtl/core/stb_back.sv =====
`default_nettype none

module stb_back import stb_pkg::*; #(
  parameter int TABLE_DEPTH = STB_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [ENTRIES_W-1:0] entries_in_use,
  input  wire logic                 q_valid,
  input  wire stb_cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > ENTRIES_W) ? CW : ENTRIES_W;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [NW-1:0]           low_r, low_nxt;
  logic [NW-1:0]           hix_r, hix_nxt;
  logic [NW-1:0]           mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [POS_W-1:0]        res_pos_r, res_pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [POS_W-1:0]        out_position_r;
  logic                    out_load;
  logic                    out_free;

  logic [NW-1:0]           n_cap;
  logic [NW:0]             mid_sum;
  logic [NW-1:0]           mid_calc;
  logic [SW-1:0]           slot_ext;
  logic                    mem_we;
  logic                    mem_re;
  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rdata_r;

  // Entries searched, capped at the table depth.
  always_comb begin
    if (NW'(entries_in_use) > NW'(TABLE_DEPTH)) begin
      n_cap = NW'(TABLE_DEPTH);
    end else begin
      n_cap = NW'(entries_in_use);
    end
  end

  // The interval is [low, hix); the midpoint is floor((low + hix - 1) / 2).
  assign mid_sum  = {1'b0, low_r} + {1'b0, hix_r} - {{NW{1'b0}}, 1'b1};
  assign mid_calc = mid_sum[NW:1];
  assign slot_ext = SW'(q_cmd.slot);

  assign out_free = !out_valid_r || !out_stall;

  // Search sequencer: one memory read and one compare per bisection step.
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hix_nxt       = hix_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_lookup) begin
            key_nxt   = q_cmd.value;
            low_nxt   = '0;
            hix_nxt   = n_cap;
            state_nxt = S_ISSUE;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        if (low_r >= hix_r) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mid_nxt   = mid_calc;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata_r == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r[POS_W-1:0];
          state_nxt     = S_DONE;
        end else if (rdata_r < key_r) begin
          low_nxt   = mid_r + NW'(1);
          state_nxt = S_ISSUE;
        end else begin
          hix_nxt   = mid_r;
          state_nxt = S_ISSUE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register holds a beat until the receiver takes it.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    low_r       <= low_nxt;
    hix_r       <= hix_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    if (out_load) begin
      out_found_r    <= res_found_r;
      out_position_r <= res_pos_r;
    end
  end

  // Key table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_ext[AW-1:0]] <= q_cmd.value;
    end
    if (mem_re) begin
      rdata_r <= mem[mid_calc[AW-1:0]];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  // A compare always works on a non-empty interval.
  a_cmp_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (low_r < hix_r))
    else $error("compare step with an empty interval");

  // The probed midpoint lies inside the interval.
  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((mid_r >= low_r) && (mid_r < hix_r)))
    else $error("midpoint outside the search interval");

  // A new result beat only comes out of the done state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised without a finished search");

  // The queue is only popped from the idle state.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (state_r == S_IDLE)))
    else $error("queue popped while a search is running");

endmodule : stb_back

`default_nettype wire

// ===== rtl/core/sorted_table_binary_search.sv =====
`default_nettype none

// Sorted-table binary search. Write beats (req_type 0) store a signed key at
// a slot of the key table; lookup beats (req_type 1) bisect positions
// 0 .. n-1, with n being entries_in_use capped at the table depth, and return
// one result beat with found and the matching position (0 when not found).
// Write beats return nothing, and a write to a slot past the table end is
// dropped. The table is not cleared at reset: every slot a lookup may probe
// must have been written first, and software keeps the entries in use sorted
// ascending. A two-beat queue sits between the input and the search engine,
// so input beats are still taken while a search runs or a result waits, until
// the queue is full. The engine stores a write straight from the idle state.
// A lookup loads the search interval, then runs bisection steps (a registered
// table read, then the compare), on a miss passes the issue state once more
// to see the interval run empty, and then loads the output register once the
// receiver has room. The table read port paces each step. entries_in_use sits
// at byte address 0 of the register port; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
module sorted_table_binary_search import stb_pkg::*; #(
  parameter int TABLE_DEPTH = STB_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Register port.
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [PADDR_W-1:0]      paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Input channel.
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_req_type,
  input  wire logic [SLOT_W-1:0]       in_slot,
  input  wire logic signed [KEY_W-1:0] in_item_value,
  // Result channel.
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_found,
  output logic [POS_W-1:0]             out_position
);

  logic [ENTRIES_W-1:0] entries_r;
  logic                 reg_sel;
  logic                 q_valid;
  logic                 q_pop;
  stb_cmd_t             q_cmd;

  // Register port: always ready, one register at word 0.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_IDX_ENTRIES);
  assign prdata  = reg_sel ? 32'(entries_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      entries_r <= pwdata[ENTRIES_W-1:0];
    end
  end

  stb_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_slot       (in_slot),
    .in_item_value (in_item_value),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  stb_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .entries_in_use (entries_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule : sorted_table_binary_search

`default_nettype wire

// ===== tb/sv/sorted_table_binary_search_checker.sv =====
`timescale 1ns / 100ps

// Watches the register port and both beat channels, keeps its own copy of the
// key table and the entry count, and checks every result beat in order.
module sorted_table_binary_search_checker import stb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [PADDR_W-1:0]      paddr,
  input  wire logic [31:0]             pwdata,
  input  wire logic                    pready,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic                    in_req_type,
  input  wire logic [SLOT_W-1:0]       in_slot,
  input  wire logic signed [KEY_W-1:0] in_item_value,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic                    out_found,
  input  wire logic [POS_W-1:0]        out_position,
  output int                           mismatch_count,
  output int                           lookups_pending
);

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
  } lookup_result_t;

  logic signed [KEY_W-1:0] key_table [0:STB_DEPTH_DEF-1];
  logic [ENTRIES_W-1:0]    entries_in_use;
  lookup_result_t          result_q [$];

  // Bisect the entries in use; a count past the table end is clamped.
  function automatic lookup_result_t search_table(input logic signed [KEY_W-1:0] key);
    lookup_result_t res;
    int lo;
    int hi;
    int mid;
    int span;
    span = (entries_in_use > STB_DEPTH_DEF) ? STB_DEPTH_DEF : int'(entries_in_use);
    lo = 0;
    hi = span - 1;
    res = '0;
    while (!res.found && hi >= lo) begin
      mid = (lo + hi) / 2;
      if (key_table[mid] == key) begin
        res.found = 1'b1;
        res.position = mid[POS_W-1:0];
      end else if (key_table[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  // Track register writes and input beats, and compare result beats.
  always @(posedge clk) begin
    lookup_result_t want;
    int errs;
    if (!rst_n) begin
      entries_in_use <= ENTRIES_RESET;
      result_q.delete();
      mismatch_count <= 0;
      lookups_pending <= 0;
      for (int i = 0; i < STB_DEPTH_DEF; i++) begin
        key_table[i] <= '0;
      end
    end else begin
      errs = 0;

      // Only word index zero holds a register; other addresses are ignored.
      if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_ENTRIES) begin
        entries_in_use <= pwdata[ENTRIES_W-1:0];
      end

      // Compare before queueing, so a stray result beat is never hidden.
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result beat with no lookup outstanding: found %0d position %0d",
                 out_found, out_position);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (out_found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, out_found);
            errs++;
          end
          if (out_position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   want.position, out_position);
            errs++;
          end
        end
      end

      // A lookup beat queues one expected result; a write beat updates the table.
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_LOOKUP) begin
          result_q.push_back(search_table(in_item_value));
        end else begin
          key_table[in_slot] <= in_item_value;
        end
      end

      lookups_pending <= result_q.size();
      mismatch_count <= mismatch_count + errs;
    end
  end

endmodule

// ===== tb/sv/sorted_table_binary_search_test.sv =====
`timescale 1ns / 100ps

module sorted_table_binary_search_test import stb_pkg::*;;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_TAIL    = 24;
  localparam int LONG_HOLD     = 300;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_BEATS = 75;

  localparam logic [PADDR_W-1:0] ENTRIES_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] SPARE_ADDR   = 3'd4;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = REQ_WRITE;
  logic [SLOT_W-1:0]       in_slot = '0;
  logic signed [KEY_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic [POS_W-1:0]        out_position;

  int mismatch_count;
  int lookups_pending;

  int   tx_pct = 0;
  int   rx_pct = 0;
  logic hold_on = 1'b0;
  logic hold_over = 1'b0;
  int   hold_cnt = 0;
  int   cycle_cnt = 0;
  int   entries_cfg = 8;

  // Keys last written per slot, used to aim lookups at stored keys.
  logic signed [KEY_W-1:0] shadow [0:STB_DEPTH_DEF-1];

  sorted_table_binary_search #(
    .TABLE_DEPTH (STB_DEPTH_DEF)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_slot       (in_slot),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position)
  );

  sorted_table_binary_search_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_position    (out_position),
    .mismatch_count  (mismatch_count),
    .lookups_pending (lookups_pending)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_table_binary_search verification failed");
      $finish;
    end
  end

  // Result side: random stall, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_on && !hold_over) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == LONG_HOLD - 1) begin
        hold_over <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // Offer one input beat after a random gap and wait until it is taken.
  task automatic send_beat(input logic kind, input logic [SLOT_W-1:0] slot,
                           input logic signed [KEY_W-1:0] value);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_slot <= slot;
    in_item_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == REQ_WRITE) begin
      shadow[slot] = value;
    end
  endtask

  // Stop sending, let every lookup come back, then give the engine time to
  // finish any trailing write beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The upper data bits are random; only the low nibble is the count.
  task automatic set_entries(input int count);
    drain();
    reg_write(ENTRIES_ADDR, ($urandom() & 32'hFFFF_FFF0) | count);
    entries_cfg = count;
  endtask

  // Lookup key: mostly a stored key or a near miss, sometimes anything.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int n;
    int sel;
    n = (entries_cfg > STB_DEPTH_DEF) ? STB_DEPTH_DEF : entries_cfg;
    sel = $urandom_range(3);
    if (n == 0 || sel == 3) return $urandom();
    if (sel == 2) return shadow[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    return shadow[$urandom_range(n - 1)];
  endfunction

  // Rewrite the entries in use with a fresh ascending key set.
  task automatic refill_sorted(output int written);
    logic signed [KEY_W-1:0] keys [0:STB_DEPTH_DEF-1];
    logic signed [KEY_W-1:0] tmp;
    int n;
    int style;
    int i;
    int j;
    n = (entries_cfg > STB_DEPTH_DEF) ? STB_DEPTH_DEF : entries_cfg;
    style = $urandom_range(2);
    for (i = 0; i < STB_DEPTH_DEF; i++) begin
      if (style == 1) begin
        keys[i] = $signed($urandom_range(15)) - 8;
      end else begin
        keys[i] = $urandom();
      end
    end
    for (i = 1; i < n; i++) begin
      tmp = keys[i];
      j = i - 1;
      while (j >= 0 && keys[j] > tmp) begin
        keys[j + 1] = keys[j];
        j--;
      end
      keys[j + 1] = tmp;
    end
    // Pin the ends of the key range on some tables.
    if (style == 2 && n > 0) begin
      keys[0] = KEY_MIN;
      keys[n - 1] = KEY_MAX;
    end
    for (i = 0; i < n; i++) begin
      send_beat(REQ_WRITE, i[SLOT_W-1:0], keys[i]);
    end
    written = n;
  endtask

  // Mostly sorted refills followed by lookups; the rest is random writes
  // that may leave the table unsorted, mixed with lookups.
  task automatic run_segment(input int beats);
    int sent;
    int written;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(3) != 0) begin
        refill_sorted(written);
        repeat (6) send_beat(REQ_LOOKUP, SLOT_W'($urandom_range(7)), pick_key());
        sent += written + 6;
      end else begin
        repeat (3) send_beat(REQ_WRITE, SLOT_W'($urandom_range(7)), $urandom());
        repeat (3) send_beat(REQ_LOOKUP, SLOT_W'($urandom_range(7)), pick_key());
        sent += 6;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table in order, with both key extremes at the ends.
    send_beat(REQ_WRITE, 3'd0, KEY_MIN);
    send_beat(REQ_WRITE, 3'd1, -32'sd1000);
    send_beat(REQ_WRITE, 3'd2, -32'sd1);
    send_beat(REQ_WRITE, 3'd3, 32'sd0);
    send_beat(REQ_WRITE, 3'd4, 32'sd1);
    send_beat(REQ_WRITE, 3'd5, 32'sd500);
    send_beat(REQ_WRITE, 3'd6, 32'sd7777);
    send_beat(REQ_WRITE, 3'd7, KEY_MAX);

    // Hit every position at the reset entry count, then some misses.
    for (int i = 0; i < STB_DEPTH_DEF; i++) begin
      send_beat(REQ_LOOKUP, SLOT_W'($urandom_range(7)), shadow[i]);
    end
    send_beat(REQ_LOOKUP, 3'd7, -32'sd2);
    send_beat(REQ_LOOKUP, 3'd0, 32'sd2);
    send_beat(REQ_LOOKUP, 3'd5, 32'sd6000);

    // An empty search, an oversized count and a single entry.
    set_entries(0);
    send_beat(REQ_LOOKUP, 3'd3, 32'sd0);
    set_entries(15);
    send_beat(REQ_LOOKUP, 3'd2, KEY_MAX);
    set_entries(1);
    send_beat(REQ_LOOKUP, 3'd1, KEY_MIN);
    send_beat(REQ_LOOKUP, 3'd6, 32'sd5);

    // A write past the register list must leave the count alone.
    drain();
    reg_write(SPARE_ADDR, $urandom());
    send_beat(REQ_LOOKUP, 3'd4, 32'sd1);

    // Random segments, each with its own entry count and idling mix.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: set_entries(8);
        1: set_entries(1);
        2: set_entries(0);
        3: set_entries(15);
        4: set_entries(3);
        5: set_entries(8);
        6: set_entries(12);
        default: set_entries(6);
      endcase
      case (seg % 4)
        0: begin
          tx_pct = 0;
          rx_pct <= 0;
        end
        1: begin
          tx_pct = 77;
          rx_pct <= 0;
        end
        2: begin
          tx_pct = 0;
          rx_pct <= 77;
        end
        default: begin
          tx_pct = 7;
          rx_pct <= 7;
        end
      endcase
      // One long result hold-off while input beats keep coming.
      if (seg == 2) begin
        hold_on <= 1'b1;
      end
      run_segment(SEGMENT_BEATS);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("sorted_table_binary_search verification clean");
    end else begin
      $display("sorted_table_binary_search verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/stb_pkg.sv
rtl/core/stb_front.sv
rtl/core/stb_back.sv
rtl/core/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_checker.sv
tb/sv/sorted_table_binary_search_test.sv
